/* design/thermal_window_throttle_macros.svh */
// Assertion macros for the thermal window throttle.
// Clocked on clock, disabled while reset is high; no other dependencies.
`ifndef THERMAL_WINDOW_THROTTLE_MACROS_SVH
`define THERMAL_WINDOW_THROTTLE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Condition that holds at every edge out of reset.
`define TWT_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("thermal window throttle: invariant violated");
// Consequence in the same cycle.
`define TWT_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("thermal window throttle: implication violated");
// Consequence in the next cycle.
`define TWT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("thermal window throttle: next-cycle check violated");
`else
`define TWT_ASSERT_ALWAYS(lbl, cond)
`define TWT_ASSERT_IMPLIES(lbl, ante, cons)
`define TWT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/twt_pkg.sv */
// Shared types and constants of the thermal window throttle.
// No dependencies; imported by the top level.
`default_nettype none

package twt_pkg;

   localparam int LIMIT_W      = 20;
   localparam int COOL_W       = 4;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [LIMIT_W-1:0] HEAT_LIMIT_RESET = 20'd20439;
   localparam logic [COOL_W-1:0]  COOLDOWN_RESET   = 4'd3;
   // Loads up to this value count as zero while idle (0.001 in Q4.12).
   localparam int unsigned        IDLE_ZERO_BAND   = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEAT_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COOLDOWN   = 2'd1;

   typedef struct packed {
      logic              ready;
      logic [COOL_W-1:0] count;
   } throttle_type;

   typedef struct packed {
      logic               unit_ready;
      logic               load_error;
      logic [LIMIT_W-1:0] window_total;
      logic [COOL_W-1:0]  cooldown_left;
   } rsp_type;

   // One forced-idle event: count down, or reload and return to ready.
   function automatic throttle_type force_idle(input throttle_type cur,
                                               input logic [COOL_W-1:0] reload);
      throttle_type nxt;
      nxt.ready = 1'b0;
      nxt.count = cur.count;
      if (cur.count != '0) begin
         nxt.count = cur.count - 1'b1;
      end else begin
         nxt.count = reload;
         nxt.ready = 1'b1;
      end
      return nxt;
   endfunction

endpackage

`default_nettype wire

/* design/thermal_window_throttle.sv */
// Top level of the thermal window throttle: control, sum, cooldown, result buffer.
// Depends on twt_pkg, twt_window and thermal_window_throttle_macros.svh.
`default_nettype none

// Thermal throttle over a ring window of WINDOW_LEN task loads (unsigned Q4.12).
// Every accepted transaction writes its load into the window and updates an
// exact running sum; once the window has been filled, a sum above limit_ff
// forces the unit idle, and each step while idle counts the cooldown down until
// it reloads from reload_ff and the unit is ready again. A load above 4 while
// idle is instead reported with load_error and dropped without touching state.
// Throughput is one transaction per clock while req_stall is low; a result is
// registered in the result register, or in the skid behind a stalled one. The
// window memory's read port is always addressed at the slot the next transaction
// will overwrite, so the evicted value is waiting in its read register and the
// read-modify-write needs no separate read. A two-deep output buffer (result
// register plus skid) lets the request side keep going while a result is
// stalled; req_stall rises only when both are full. Reset clears the window
// through per-entry valid bits at once, so there is no clearing pass. csr_ready
// is always high; write the registers only while no transaction is in flight.

`include "thermal_window_throttle_macros.svh"

module thermal_window_throttle #(
   parameter int WINDOW_LEN = 10,
   parameter int LOAD_BITS  = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [LOAD_BITS-1:0]             req_task_load,
   // result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_unit_ready,
   output logic                                  rsp_load_error,
   output logic [twt_pkg::LIMIT_W-1:0]           rsp_window_total,
   output logic [twt_pkg::COOL_W-1:0]            rsp_cooldown_left,
   // configuration write channel
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [twt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [twt_pkg::LIMIT_W-1:0]      csr_wdata
);

   import twt_pkg::*;

   localparam int SLOT_W = $clog2(WINDOW_LEN);
   localparam int SUM_W  = LOAD_BITS + $clog2(WINDOW_LEN);
   localparam int CMP_W  = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);

   // configuration registers
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [COOL_W-1:0]  reload_ff, reload_in;

   // throttle state
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SLOT_W-1:0]  items_ff, items_in;
   logic [SUM_W-1:0]   total_ff, total_in;
   logic               ready_ff, ready_in;
   logic [COOL_W-1:0]  cool_ff, cool_in;

   // result buffer
   logic               rsp_valid_ff, rsp_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   rsp_type            out_ff, out_in;
   rsp_type            skid_ff, skid_in;

   // step datapath
   logic               accept;
   logic               out_take;
   logic [LOAD_BITS-1:0] old_load;
   logic [SUM_W-1:0]   sum_new;
   logic               full;
   logic               over;
   logic               load_err;
   logic               adv;
   logic               step;
   throttle_type       thr;
   logic [SLOT_W-1:0]  slot_next;
   logic [SLOT_W-1:0]  rd_addr;
   logic [CMP_W-1:0]   total_ext;
   rsp_type            new_rsp;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_take  = rsp_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;

   // Evicted entry: the read register holds window[slot_ff] by construction.
   twt_window #(
      .WINDOW_LEN (WINDOW_LEN),
      .LOAD_BITS  (LOAD_BITS)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (step),
      .wr_addr (slot_ff),
      .wr_data (req_task_load),
      .rd_addr (rd_addr),
      .rd_data (old_load)
   );

   // Evaluate one transaction against the current state.
   always_comb begin
      sum_new  = total_ff - SUM_W'(old_load) + SUM_W'(req_task_load);
      full     = (items_ff == LAST_SLOT);
      over     = full && (CMP_W'(sum_new) > CMP_W'(limit_ff));
      thr      = '{ready: ready_ff, count: cool_ff};
      load_err = 1'b0;
      adv      = 1'b0;
      if (ready_ff) begin
         adv = 1'b1;
         if (over) begin
            thr = force_idle(thr, reload_ff);
         end
      end else if (req_task_load > LOAD_BITS'(IDLE_ZERO_BAND)) begin
         // drop the load: nothing moves
         load_err = 1'b1;
      end else begin
         adv = 1'b1;
         thr = force_idle(thr, reload_ff);
         // second event on the same step when the window is still hot
         if (over) begin
            thr = force_idle(thr, reload_ff);
         end
      end
   end

   assign step      = accept && adv;
   assign slot_next = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
   // Point the read port at the slot the next write will use.
   assign rd_addr   = step ? slot_next : slot_ff;

   assign total_ext = CMP_W'(adv ? sum_new : total_ff);

   always_comb begin
      new_rsp.unit_ready    = thr.ready;
      new_rsp.load_error    = load_err;
      new_rsp.window_total  = total_ext[LIMIT_W-1:0];
      new_rsp.cooldown_left = thr.count;
   end

   // Next state of the throttle.
   always_comb begin
      slot_in  = slot_ff;
      items_in = items_ff;
      total_in = total_ff;
      ready_in = ready_ff;
      cool_in  = cool_ff;
      if (accept) begin
         ready_in = thr.ready;
         cool_in  = thr.count;
      end
      if (step) begin
         slot_in  = slot_next;
         total_in = sum_new;
         if (!full) begin
            items_in = items_ff + 1'b1;
         end
      end
   end

   // Configuration writes.
   always_comb begin
      limit_in  = limit_ff;
      reload_in = reload_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HEAT_LIMIT: limit_in  = csr_wdata;
            CSR_COOLDOWN:   reload_in = csr_wdata[COOL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Result register plus skid: a stalled result never blocks the next request
   // until both slots are occupied.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || out_take) begin
            out_in       = new_rsp;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = new_rsp;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= HEAT_LIMIT_RESET;
         reload_ff     <= COOLDOWN_RESET;
         slot_ff       <= '0;
         items_ff      <= '0;
         total_ff      <= '0;
         ready_ff      <= 1'b1;
         cool_ff       <= COOLDOWN_RESET;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         limit_ff      <= limit_in;
         reload_ff     <= reload_in;
         slot_ff       <= slot_in;
         items_ff      <= items_in;
         total_ff      <= total_in;
         ready_ff      <= ready_in;
         cool_ff       <= cool_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload holds without reset.
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_unit_ready    = out_ff.unit_ready;
   assign rsp_load_error    = out_ff.load_error;
   assign rsp_window_total  = out_ff.window_total;
   assign rsp_cooldown_left = out_ff.cooldown_left;

   `TWT_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_ff || rsp_valid_ff)
   `TWT_ASSERT_ALWAYS(a_slot_in_range, slot_ff <= LAST_SLOT)
   `TWT_ASSERT_IMPLIES(a_err_only_idle, accept && load_err, !ready_ff)
   `TWT_ASSERT_NEXT(a_err_no_change, accept && load_err, $stable(slot_ff) && $stable(total_ff))
   `TWT_ASSERT_NEXT(a_step_advances, step, slot_ff != $past(slot_ff))

endmodule

`default_nettype wire

/* design/twt_window.sv */
// Load window memory: one write port, one registered read port.
// Entries never written read as zero through per-entry valid bits.
`default_nettype none

module twt_window #(
   parameter int WINDOW_LEN = 10,
   parameter int LOAD_BITS  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(WINDOW_LEN)-1:0] wr_addr,
   input  wire logic [LOAD_BITS-1:0]          wr_data,
   input  wire logic [$clog2(WINDOW_LEN)-1:0] rd_addr,
   output logic      [LOAD_BITS-1:0]          rd_data
);

   logic [LOAD_BITS-1:0]  mem [WINDOW_LEN];
   logic [WINDOW_LEN-1:0] valid_ff;
   logic [LOAD_BITS-1:0]  rd_data_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

/* test/thermal_window_throttle_test.sv */
// Self-checking testbench for the thermal window throttle: directed and random loads.
// Depends on twt_pkg and the thermal_window_throttle RTL only.
`timescale 1ns / 100ps

module thermal_window_throttle_test;

   import twt_pkg::*;

   localparam int WIN    = 10;
   localparam int LOAD_W = 16;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [LOAD_W-1:0]      req_task_load = '0;

   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_unit_ready;
   logic                   rsp_load_error;
   logic [LIMIT_W-1:0]     rsp_window_total;
   logic [COOL_W-1:0]      rsp_cooldown_left;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_HEAT_LIMIT;
   logic [LIMIT_W-1:0]     csr_wdata = '0;

   always #2 clock = ~clock;

   thermal_window_throttle #(
      .WINDOW_LEN (WIN),
      .LOAD_BITS  (LOAD_W)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_task_load     (req_task_load),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_unit_ready    (rsp_unit_ready),
      .rsp_load_error    (rsp_load_error),
      .rsp_window_total  (rsp_window_total),
      .rsp_cooldown_left (rsp_cooldown_left),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Throttle predictor state, starting from the reset values.
   // ------------------------------------------------------------------
   logic [LOAD_W-1:0]  window_loads [WIN] = '{default: '0};
   int unsigned        write_pos   = 0;
   int unsigned        fill_count  = 0;   // saturates at WIN-1
   int unsigned        load_sum    = 0;   // exact window sum
   logic [COOL_W-1:0]  cool_count  = COOLDOWN_RESET;
   logic               ready_now   = 1'b1;
   logic [LIMIT_W-1:0] heat_limit  = HEAT_LIMIT_RESET;
   logic [COOL_W-1:0]  cool_reload = COOLDOWN_RESET;

   rsp_type            expected_rsps [$];

   // Transaction counters that let stimulus wait for the monitor to catch up.
   int unsigned        loads_sent  = 0;
   int unsigned        loads_taken = 0;
   int unsigned        csr_sent    = 0;
   int unsigned        csr_taken   = 0;
   int unsigned        mismatches  = 0;

   // Idling controls for the two channels.
   bit                 req_gaps_on  = 1'b0;
   bit                 rsp_stall_on = 1'b0;
   int unsigned        stall_left   = 0;

   // One cooldown tick: count down while hot, or reload and go ready at zero.
   function void cool_tick();
      ready_now = 1'b0;
      if (cool_count != '0) begin
         cool_count = cool_count - 1'b1;
      end else begin
         cool_count = cool_reload;
         ready_now  = 1'b1;
      end
   endfunction

   // Replace the oldest window entry and keep the sum exact.
   function void store_load(input logic [LOAD_W-1:0] load);
      load_sum = load_sum - window_loads[write_pos] + load;
      window_loads[write_pos] = load;
   endfunction

   function void advance_slot();
      write_pos = (write_pos + 1) % WIN;
      if (fill_count < WIN - 1) begin
         fill_count++;
      end
   endfunction

   // Apply one transaction to the predictor and return the result it must produce.
   function rsp_type throttle_step(input logic [LOAD_W-1:0] load);
      rsp_type r;
      bit      full;
      bit      err;
      full = (fill_count >= WIN - 1);
      err  = 1'b0;
      if (ready_now) begin
         store_load(load);
         if (full && load_sum > heat_limit) begin
            cool_tick();
         end
         advance_slot();
      end else if (load > IDLE_ZERO_BAND) begin
         // Drop the load: hot unit takes nothing but near-zero loads.
         err = 1'b1;
      end else begin
         store_load(load);
         cool_tick();
         // Check the window a second time while still idle.
         if (full && load_sum > heat_limit) begin
            cool_tick();
         end
         advance_slot();
      end
      r.unit_ready    = ready_now;
      r.load_error    = err;
      r.window_total  = load_sum[LIMIT_W-1:0];
      r.cooldown_left = cool_count;
      return r;
   endfunction

   // Print one line per mismatch and count every one.
   task report_mismatch(input string what, input longint got, input longint want);
      $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // ------------------------------------------------------------------
   // Monitor: predict on every accepted request, apply every accepted
   // register write, and check every accepted result against the oldest
   // expectation. All handshakes are sampled at the rising edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : throttle_monitor
      rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HEAT_LIMIT: heat_limit  = csr_wdata;
               CSR_COOLDOWN:   cool_reload = csr_wdata[COOL_W-1:0];
               default: ;
            endcase
            csr_taken++;
         end
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(throttle_step(req_task_load));
            loads_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected result", rsp_window_total, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_unit_ready !== want.unit_ready)
                  report_mismatch("unit_ready", rsp_unit_ready, want.unit_ready);
               if (rsp_load_error !== want.load_error)
                  report_mismatch("load_error", rsp_load_error, want.load_error);
               if (rsp_window_total !== want.window_total)
                  report_mismatch("window_total", rsp_window_total, want.window_total);
               if (rsp_cooldown_left !== want.cooldown_left)
                  report_mismatch("cooldown_left", rsp_cooldown_left, want.cooldown_left);
            end
         end
      end
   end

   // Result-side backpressure: mostly short stalls, now and then a long one.
   always @(posedge clock) begin : rsp_backpressure
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!rsp_stall_on || roll < 60) begin
         rsp_stall <= 1'b0;
      end else if (roll < 93) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(8, 30);
      end
   end

   // Request-side gap length: mostly none, some short, a few long.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (!req_gaps_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   // Send one load. Leave valid high afterward so back-to-back transactions
   // never drop and raise valid in the same step; drain_results lowers it.
   task send_load(input logic [LOAD_W-1:0] load);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_task_load <= load;
      loads_sent++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // Hold until the monitor has predicted this transaction.
      wait (loads_taken == loads_sent);
   endtask

   // Drop valid, wait for every expected result, then let the pipe settle.
   task drain_results();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write both registers with no transaction in flight. Random upper bits on the
   // cooldown write must be ignored.
   task set_config(input logic [LIMIT_W-1:0] limit, input logic [COOL_W-1:0] reload);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= CSR_HEAT_LIMIT;
      csr_wdata <= limit;
      csr_sent++;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_COOLDOWN;
      csr_wdata <= {16'($urandom_range(0, 65535)), reload};
      csr_sent++;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      wait (csr_taken == csr_sent);
   endtask

   // Random load shaped by the predicted state: near-zero loads while hot with
   // some errors mixed in, and mostly loads around the limit's average while ready.
   function automatic logic [LOAD_W-1:0] pick_load();
      int unsigned roll;
      int unsigned target;
      int unsigned lo;
      int unsigned hi;
      roll = $urandom_range(0, 99);
      if (!ready_now) begin
         if (roll < 70) return LOAD_W'($urandom_range(0, IDLE_ZERO_BAND));
         if (roll < 85) return LOAD_W'($urandom_range(IDLE_ZERO_BAND + 1, 65535));
         return LOAD_W'($urandom());
      end
      if (roll < 5)  return '0;
      if (roll < 10) return '1;
      if (roll < 25) return LOAD_W'($urandom());
      target = heat_limit / WIN;
      lo     = target - target / 3;
      hi     = target + target / 3;
      if (hi > 65535) hi = 65535;
      if (lo > hi) lo = hi;
      return LOAD_W'($urandom_range(lo, hi));
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Fill the window with full-scale loads at the reset settings; the tenth
   // transaction sees a full window far above the limit and trips the unit.
   task test_window_trip();
      req_gaps_on  = 1'b0;
      rsp_stall_on = 1'b0;
      repeat (WIN) send_load('1);
   endtask

   // While hot: the first load above the zero band is an error, the band edge
   // and small loads are stored, a full-scale load is dropped, and zeros
   // walk the window sum down while the unit stays hot.
   task test_idle_loads();
      req_gaps_on  = 1'b1;
      rsp_stall_on = 1'b1;
      send_load(LOAD_W'(IDLE_ZERO_BAND + 1));
      send_load(LOAD_W'(IDLE_ZERO_BAND));
      send_load(LOAD_W'(1));
      send_load('1);
      repeat (6) send_load('0);
   endtask

   // Register extremes: zero limit with zero cooldown, then the widest limit
   // with the longest cooldown.
   task test_config_extremes();
      set_config('0, '0);
      send_load(LOAD_W'(1));
      send_load(LOAD_W'(16'h8000));
      set_config('1, '1);
      send_load('1);
      send_load('0);
   endtask

   // Phases of random loads under different settings and idling mixes.
   task test_random_phases();
      logic [LIMIT_W-1:0] limit;
      logic [COOL_W-1:0]  reload;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       limit = HEAT_LIMIT_RESET;
            1:       limit = '0;
            2:       limit = LIMIT_W'(655350);
            3:       limit = '1;
            default: limit = LIMIT_W'($urandom_range(0, 655350));
         endcase
         if (phase == 1)
            reload = '0;
         else if (phase == 2)
            reload = '1;
         else
            reload = COOL_W'($urandom_range(0, 15));
         set_config(limit, reload);
         // Rotate idling so some phases run with no gaps or no stalls.
         req_gaps_on  = (phase % 3) != 1;
         rsp_stall_on = (phase % 3) != 2;
         for (int n = 0; n < 250; n++) begin
            send_load(pick_load());
         end
      end
   endtask

   initial begin : test_sequence
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_window_trip();
      test_idle_loads();
      test_config_extremes();
      test_random_phases();
      drain_results();
      if (mismatches == 0)
         $display("thermal_window_throttle test passed");
      else
         $display("thermal_window_throttle test failed");
      $finish;
   end

   // Stop a hung run.
   initial begin : watchdog
      #4_000_000;
      $display("thermal_window_throttle test failed");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/twt_pkg.sv
design/twt_window.sv
design/thermal_window_throttle.sv
test/thermal_window_throttle_test.sv
